@@ hw/rtl/nine_bit_spi_frame_packer_assert.svh @@
// Assertion macros for the checker file of the frame packer.
`ifndef NINE_BIT_SPI_FRAME_PACKER_ASSERT_SVH
`define NINE_BIT_SPI_FRAME_PACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame packer check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define NBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame packer check failed in the following cycle");

`endif

@@ hw/rtl/nbsp_pkg.sv @@
package nbsp_pkg;

	// Item kinds.
	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		CFG_X_OFFSET   = 3'd0,
		CFG_Y_OFFSET   = 3'd1,
		CFG_COLUMN_CMD = 3'd2,
		CFG_ROW_CMD    = 3'd3,
		CFG_WRITE_CMD  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] COLUMN_CMD_RST = 8'd42;
	localparam logic [7:0] ROW_CMD_RST    = 8'd43;
	localparam logic [7:0] WRITE_CMD_RST  = 8'd44;

	// Byte counts of the possible bursts.
	localparam logic [4:0] BYTES_ONE_GROUP    = 5'd9;
	localparam logic [4:0] BYTES_TWO_GROUPS   = 5'd18;
	localparam logic [4:0] BYTES_THREE_GROUPS = 5'd27;

	typedef struct packed {
		logic       kind;
		logic [9:0] x_start;
		logic [9:0] x_end;
		logic [9:0] y_start;
		logic [9:0] y_end;
		logic [7:0] pixel_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_run;
	} result_t;

	// Moves a group whose newest word sits in the low nine bits, with n + 1 words
	// in it, up so that its oldest word is at the top; zero words fill the rest.
	function automatic logic [71:0] align_group(input logic [71:0] v, input logic [2:0] n);
		logic [71:0] r;
		case (n)
			3'd0: r = v << 63;
			3'd1: r = v << 54;
			3'd2: r = v << 45;
			3'd3: r = v << 36;
			3'd4: r = v << 27;
			3'd5: r = v << 18;
			3'd6: r = v << 9;
			default: r = v;
		endcase
		return r;
	endfunction

	// The sixteen header words, first word at the top.
	function automatic logic [143:0] header_words(
		input logic [7:0]  col_cmd,
		input logic [7:0]  rw_cmd,
		input logic [7:0]  wr_cmd,
		input logic [10:0] xs,
		input logic [10:0] xe,
		input logic [10:0] ys,
		input logic [10:0] ye
	);
		return {1'b0, col_cmd,
			1'b1, 5'b0, xs[10:8], 1'b1, xs[7:0],
			1'b1, 5'b0, xe[10:8], 1'b1, xe[7:0],
			1'b0, rw_cmd,
			1'b1, 5'b0, ys[10:8], 1'b1, ys[7:0],
			1'b1, 5'b0, ye[10:8], 1'b1, ye[7:0],
			45'b0,
			1'b0, wr_cmd};
	endfunction

endpackage

@@ hw/rtl/nine_bit_spi_frame_packer.sv @@
// Channel   Direction  Handshake            Beat
// in        sink       in_valid / in_stall  item_t: window corners or one pixel byte
// out       source     out_valid / out_stall result_t: one packed byte, end of run flag
// cfg       sink       cfg_valid / cfg_ready register index and write data
//
// An accepted item is held in the input register, where its pending words and
// any finished groups are worked out. Items that finish no group pass at one a cycle;
// one that finishes groups waits there until the byte buffer is free, so the output
// sets the pace: eight pixel bytes leave as nine bytes, and a window as 18 or 27 bytes.
// Reset empties the pending words and the byte buffer and restores the registers.
// An output stall holds the current byte; pixels that finish no group still pass, and
// the first item that needs the buffer waits in the input register and stalls the input.
module nine_bit_spi_frame_packer import nbsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  item_t      in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);

	// Configuration registers.
	logic [8:0] x_offset_q;
	logic [8:0] y_offset_q;
	logic [7:0] column_cmd_q;
	logic [7:0] row_cmd_q;
	logic [7:0] write_cmd_q;

	// Words not yet sent: up to seven, newest in the low nine bits.
	logic [62:0] pending_q;
	logic [2:0]  count_q;

	// Input register.
	logic  valid_s1;
	item_t item_s1;

	// Byte buffer: first byte to go at the top, and the bytes left in it.
	logic [215:0] buf_q;
	logic [4:0]   rem_q;

	logic         buf_free;
	logic         emit;
	logic         advance;
	logic         pix_emit;
	logic         pad_emit;
	logic [71:0]  pix_group;
	logic [71:0]  pad_group;
	logic [143:0] hdr;
	logic [10:0]  xs;
	logic [10:0]  xe;
	logic [10:0]  ys;
	logic [10:0]  ye;
	logic [215:0] load_bytes;
	logic [4:0]   load_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q   <= '0;
			y_offset_q   <= '0;
			column_cmd_q <= COLUMN_CMD_RST;
			row_cmd_q    <= ROW_CMD_RST;
			write_cmd_q  <= WRITE_CMD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_OFFSET:   x_offset_q   <= cfg_data;
				CFG_Y_OFFSET:   y_offset_q   <= cfg_data;
				CFG_COLUMN_CMD: column_cmd_q <= cfg_data[7:0];
				CFG_ROW_CMD:    row_cmd_q    <= cfg_data[7:0];
				CFG_WRITE_CMD:  write_cmd_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The buffer can take a new burst once its last byte leaves this cycle.
	assign buf_free = (rem_q == 5'd0) || ((rem_q == 5'd1) && !out_stall);

	always_comb begin
		// A pixel completes a group when seven words are pending, and a last
		// pixel closes whatever partial group it leaves.
		pix_group = align_group({pending_q, 1'b1, item_s1.pixel_byte}, count_q);
		pix_emit  = (count_q == 3'd7) || item_s1.last;

		// A window first pads a partial group with zero words.
		pad_group = align_group({pending_q, 9'b0}, count_q);
		pad_emit  = (count_q != 3'd0);

		xs  = {1'b0, item_s1.x_start} + {2'b0, x_offset_q};
		xe  = {1'b0, item_s1.x_end} + {2'b0, x_offset_q};
		ys  = {1'b0, item_s1.y_start} + {2'b0, y_offset_q};
		ye  = {1'b0, item_s1.y_end} + {2'b0, y_offset_q};
		hdr = header_words(column_cmd_q, row_cmd_q, write_cmd_q, xs, xe, ys, ye);

		if (item_s1.kind == KIND_PIXEL) begin
			emit       = pix_emit;
			load_bytes = {pix_group, 144'b0};
			load_count = BYTES_ONE_GROUP;
		end else if (pad_emit) begin
			emit       = 1'b1;
			load_bytes = {pad_group, hdr};
			load_count = BYTES_THREE_GROUPS;
		end else begin
			emit       = 1'b1;
			load_bytes = {hdr, 72'b0};
			load_count = BYTES_TWO_GROUPS;
		end

		advance  = valid_s1 && (!emit || buf_free);
		in_stall = valid_s1 && !advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Pending words move on as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
		end else if (advance) begin
			if (item_s1.kind == KIND_WINDOW || pix_emit) begin
				pending_q <= '0;
				count_q   <= '0;
			end else begin
				pending_q <= {pending_q[53:0], 1'b1, item_s1.pixel_byte};
				count_q   <= count_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (advance && emit) begin
			rem_q <= load_count;
		end else if (out_valid && !out_stall) begin
			rem_q <= rem_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			buf_q <= load_bytes;
		end else if (out_valid && !out_stall) begin
			buf_q <= buf_q << 8;
		end
	end

	assign out_valid           = (rem_q != 5'd0);
	assign out_data.out_byte   = buf_q[215:208];
	assign out_data.end_of_run = (rem_q == 5'd1);

endmodule

@@ hw/rtl/nbsp_checker.sv @@
`include "nine_bit_spi_frame_packer_assert.svh"

module nbsp_checker import nbsp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_stall,
	input logic    out_valid,
	input logic    out_stall,
	input result_t out_data
);

	// A stalled output beat holds.
	`NBSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// Output stays valid between the bytes of one run until its end.
	`NBSP_ASSERT_NEXT(a_run_contiguous, clk, arst_n, out_valid && !out_stall && !out_data.end_of_run, out_valid)

	// Output goes quiet only after the closing byte of a run.
	`NBSP_ASSERT_SAME(a_idle_after_end, clk, arst_n, $fell(out_valid), $past(out_data.end_of_run))

	// With nothing to send, the input side is never held back.
	`NBSP_ASSERT_SAME(a_no_stall_when_idle, clk, arst_n, !out_valid, !in_stall)

endmodule

bind nine_bit_spi_frame_packer nbsp_checker u_nbsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
